// ----- design/framebuffer_pixel_writer_assert.svh -----
// assertion macros shared by the checker
`ifndef FRAMEBUFFER_PIXEL_WRITER_ASSERT_SVH
`define FRAMEBUFFER_PIXEL_WRITER_ASSERT_SVH

// same-cycle implication, switched off while reset is high
`define FBPW_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fbpw check failed");

// next-cycle implication, also checked during reset
`define FBPW_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("fbpw check failed");

`endif

// ----- design/fbpw_pkg.sv -----
package fbpw_pkg;

   localparam int COORD_W    = 8;
   localparam int COLOUR_W   = 16;
   localparam int DIM_W      = 9;
   localparam int ROW_W      = 10;
   localparam int ADDR_OUT_W = 13;
   localparam int COUNT_W    = 2;
   localparam int PROD_W     = DIM_W + ROW_W;
   localparam int CALC_W     = 21;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;

   localparam int MIRROR_X_BIT = 0;
   localparam int MIRROR_Y_BIT = 1;

   localparam logic [7:0] PIX1_MASK = 8'h80;
   localparam logic [7:0] PIX2_MASK = 8'hC0;
   localparam logic [7:0] PIX4_MASK = 8'hF0;
   localparam logic [7:0] BYTE_MASK = 8'hFF;

   localparam logic [DIM_W-1:0] RESET_WIDTH     = 9'd128;
   localparam logic [DIM_W-1:0] RESET_HEIGHT    = 9'd64;
   localparam logic [ROW_W-1:0] RESET_ROW_BYTES = 10'd16;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   localparam logic [COUNT_W-1:0] COUNT_NONE = 2'd0;
   localparam logic [COUNT_W-1:0] COUNT_ONE  = 2'd1;
   localparam logic [COUNT_W-1:0] COUNT_TWO  = 2'd2;

   typedef enum logic [1:0] {
      ROT_0,
      ROT_90,
      ROT_180,
      ROT_270
   } rotation_type;

   typedef enum logic [1:0] {
      FMT_1BPP,
      FMT_2BPP,
      FMT_4BPP,
      FMT_16BPP
   } format_type;

   typedef enum logic [2:0] {
      REG_ROTATION,
      REG_MIRROR,
      REG_FORMAT,
      REG_WIDTH,
      REG_HEIGHT,
      REG_ROW_BYTES
   } reg_index_type;

   typedef struct packed {
      logic [COORD_W-1:0]  x_pos;
      logic [COORD_W-1:0]  y_pos;
      logic [COLOUR_W-1:0] colour;
   } req_type;

   typedef struct packed {
      logic                  status;
      logic [ADDR_OUT_W-1:0] byte_address;
      logic [COLOUR_W-1:0]   written_data;
      logic [COUNT_W-1:0]    byte_count;
   } rsp_type;

   typedef struct packed {
      rotation_type      rotation;
      logic [1:0]        mirror_mode;
      format_type        pixel_format;
      logic [DIM_W-1:0]  panel_width;
      logic [DIM_W-1:0]  panel_height;
      logic [ROW_W-1:0]  row_bytes;
   } cfg_type;

   // a classified pixel write on its way from front to back
   typedef struct packed {
      logic                out_of_range;
      logic [DIM_W-1:0]    px;
      logic [DIM_W-1:0]    py;
      logic [COLOUR_W-1:0] colour;
   } point_type;

endpackage

// ----- design/fbpw_csr.sv -----
module fbpw_csr import fbpw_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_sel;
   logic          wr_en;

   assign reg_sel = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_ROTATION:  cfg_in.rotation     = rotation_type'(pwdata[1:0]);
            REG_MIRROR:    cfg_in.mirror_mode  = pwdata[1:0];
            REG_FORMAT:    cfg_in.pixel_format = format_type'(pwdata[1:0]);
            REG_WIDTH:     cfg_in.panel_width  = pwdata[DIM_W-1:0];
            REG_HEIGHT:    cfg_in.panel_height = pwdata[DIM_W-1:0];
            REG_ROW_BYTES: cfg_in.row_bytes    = pwdata[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      case (reg_sel)
         REG_ROTATION:  prdata = CSR_DATA_W'(cfg_ff.rotation);
         REG_MIRROR:    prdata = CSR_DATA_W'(cfg_ff.mirror_mode);
         REG_FORMAT:    prdata = CSR_DATA_W'(cfg_ff.pixel_format);
         REG_WIDTH:     prdata = CSR_DATA_W'(cfg_ff.panel_width);
         REG_HEIGHT:    prdata = CSR_DATA_W'(cfg_ff.panel_height);
         REG_ROW_BYTES: prdata = CSR_DATA_W'(cfg_ff.row_bytes);
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rotation     <= ROT_0;
         cfg_ff.mirror_mode  <= 2'b00;
         cfg_ff.pixel_format <= FMT_1BPP;
         cfg_ff.panel_width  <= RESET_WIDTH;
         cfg_ff.panel_height <= RESET_HEIGHT;
         cfg_ff.row_bytes    <= RESET_ROW_BYTES;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- design/fbpw_front.sv -----
module fbpw_front import fbpw_pkg::*; #(
   parameter int MAX_DIM = 256
) (
   input  cfg_type   cfg,
   input  logic      push,
   input  req_type   req_item,
   input  logic      q_full,
   input  logic      clearing,
   output logic      full,
   output logic      q_push,
   output point_type point
);

   localparam int               CLAMP_W   = 11;
   localparam logic [CLAMP_W-1:0] MAX_DIM_C = CLAMP_W'(MAX_DIM);

   logic [DIM_W-1:0] pw;
   logic [DIM_W-1:0] ph;
   logic [DIM_W-1:0] lw;
   logic [DIM_W-1:0] lh;
   logic [DIM_W-1:0] xe;
   logic [DIM_W-1:0] ye;
   logic [DIM_W-1:0] rx;
   logic [DIM_W-1:0] ry;
   logic             swapped;

   assign full   = q_full | clearing;
   assign q_push = push & ~full;

   assign pw = ({2'b00, cfg.panel_width} > MAX_DIM_C) ? DIM_W'(MAX_DIM) : cfg.panel_width;
   assign ph = ({2'b00, cfg.panel_height} > MAX_DIM_C) ? DIM_W'(MAX_DIM) : cfg.panel_height;

   assign swapped = (cfg.rotation == ROT_90) || (cfg.rotation == ROT_270);
   assign lw      = swapped ? ph : pw;
   assign lh      = swapped ? pw : ph;
   assign xe      = {1'b0, req_item.x_pos};
   assign ye      = {1'b0, req_item.y_pos};

   always_comb begin
      case (cfg.rotation)
         ROT_0: begin
            rx = xe;
            ry = ye;
         end
         ROT_90: begin
            rx = pw - ye - 9'd1;
            ry = xe;
         end
         ROT_180: begin
            rx = pw - xe - 9'd1;
            ry = ph - ye - 9'd1;
         end
         default: begin
            rx = ye;
            ry = ph - xe - 9'd1;
         end
      endcase
   end

   always_comb begin
      point.out_of_range = (xe >= lw) || (ye >= lh);
      point.px           = cfg.mirror_mode[MIRROR_X_BIT] ? (pw - rx - 9'd1) : rx;
      point.py           = cfg.mirror_mode[MIRROR_Y_BIT] ? (ph - ry - 9'd1) : ry;
      point.colour       = req_item.colour;
   end

endmodule

// ----- design/fbpw_queue.sv -----
module fbpw_queue import fbpw_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  point_type push_item,
   input  logic      pop,
   output logic      full,
   output logic      empty,
   output point_type head
);

   point_type              entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff;
   logic [QUEUE_PTR_W:0]   count_in;

   assign full  = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- design/fbpw_back.sv -----
module fbpw_back import fbpw_pkg::*; #(
   parameter int FRAME_BYTES = 8192
) (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      q_empty,
   input  point_type q_head,
   output logic      q_pop,
   output logic      clearing,
   input  logic      pop,
   output logic      empty,
   output rsp_type   rsp_item
);

   localparam int                 BANK_DEPTH  = (FRAME_BYTES + 1) / 2;
   localparam int                 IDX_W       = $clog2(BANK_DEPTH);
   localparam logic [CALC_W-1:0]  FRAME_LIMIT = CALC_W'(FRAME_BYTES);
   localparam logic [IDX_W-1:0]   LAST_IDX    = IDX_W'(BANK_DEPTH - 1);

   typedef struct packed {
      logic                out_of_range;
      logic [PROD_W-1:0]   row_base;
      logic [ROW_W-1:0]    px_off;
      logic [2:0]          px_lo;
      logic [COLOUR_W-1:0] colour;
   } s1_type;

   typedef struct packed {
      logic                out_of_range;
      logic [CALC_W-1:0]   addr;
      logic [IDX_W-1:0]    idx_next;
      logic [2:0]          px_lo;
      logic [COLOUR_W-1:0] colour;
   } s2_type;

   // framebuffer split into even and odd byte banks so a 16 bpp pixel
   // writes both of its bytes in the same cycle
   logic [7:0]       bank_even_ff [BANK_DEPTH];
   logic [7:0]       bank_odd_ff  [BANK_DEPTH];
   logic [7:0]       rd_even_ff;
   logic [7:0]       rd_odd_ff;

   s1_type           s1_ff;
   s1_type           s1_in;
   s2_type           s2_ff;
   s2_type           s2_in;
   rsp_type          out_ff;
   rsp_type          rsp_in;
   logic             s1_valid_ff;
   logic             s1_valid_in;
   logic             s2_valid_ff;
   logic             s2_valid_in;
   logic             out_valid_ff;
   logic             out_valid_in;
   logic             clearing_ff;
   logic             clearing_in;
   logic [IDX_W-1:0] clear_idx_ff;
   logic [IDX_W-1:0] clear_idx_in;

   // most recent write to each bank, for a read issued in the same cycle
   logic             lw_even_valid_ff;
   logic [IDX_W-1:0] lw_even_idx_ff;
   logic [7:0]       lw_even_data_ff;
   logic             lw_odd_valid_ff;
   logic [IDX_W-1:0] lw_odd_idx_ff;
   logic [7:0]       lw_odd_data_ff;

   logic             s1_go;
   logic             s2_go;
   logic [CALC_W-1:0] last_addr;
   logic [IDX_W-1:0] rd_idx;
   logic [IDX_W-1:0] s2_idx;
   logic             byte_sel;
   logic [7:0]       old_even;
   logic [7:0]       old_odd;
   logic [7:0]       old_byte;
   logic [7:0]       new_byte;
   logic [7:0]       bit_mask;
   logic [2:0]       sh2;
   logic [2:0]       sh4;

   logic             we_even;
   logic             we_odd;
   logic [IDX_W-1:0] w_idx_even;
   logic [IDX_W-1:0] w_idx_odd;
   logic [7:0]       w_data_even;
   logic [7:0]       w_data_odd;

   assign clearing = clearing_ff;
   assign empty    = ~out_valid_ff;
   assign rsp_item = out_ff;

   assign s2_go = s2_valid_ff & (~out_valid_ff | pop);
   assign s1_go = s1_valid_ff & (~s2_valid_ff | s2_go);
   assign q_pop = ~q_empty & ~clearing_ff & (~s1_valid_ff | s1_go);

   always_comb begin
      s1_valid_in  = q_pop | (s1_valid_ff & ~s1_go);
      s2_valid_in  = s1_go | (s2_valid_ff & ~s2_go);
      out_valid_in = s2_go | (out_valid_ff & ~pop);
      clearing_in  = clearing_ff;
      clear_idx_in = clear_idx_ff;
      if (clearing_ff) begin
         clear_idx_in = clear_idx_ff + 1'b1;
         if (clear_idx_ff == LAST_IDX) begin
            clearing_in = 1'b0;
         end
      end
   end

   // stage 1: row base through the multiplier, column offset per format
   always_comb begin
      s1_in.out_of_range = q_head.out_of_range;
      s1_in.row_base     = PROD_W'(q_head.py) * PROD_W'(cfg.row_bytes);
      s1_in.px_lo        = q_head.px[2:0];
      s1_in.colour       = q_head.colour;
      case (cfg.pixel_format)
         FMT_1BPP:  s1_in.px_off = ROW_W'(q_head.px >> 3);
         FMT_2BPP:  s1_in.px_off = ROW_W'(q_head.px >> 2);
         FMT_4BPP:  s1_in.px_off = ROW_W'(q_head.px >> 1);
         default:   s1_in.px_off = {q_head.px, 1'b0};
      endcase
   end

   // stage 2: byte address, store bound check, bank read issue
   always_comb begin
      s2_in.addr   = CALC_W'(s1_ff.row_base) + CALC_W'(s1_ff.px_off);
      last_addr    = (cfg.pixel_format == FMT_16BPP) ? s2_in.addr + 1'b1 : s2_in.addr;
      s2_in.out_of_range = s1_ff.out_of_range | (last_addr >= FRAME_LIMIT);
      rd_idx         = s2_in.addr[IDX_W:1];
      s2_in.idx_next = rd_idx + 1'b1;
      s2_in.px_lo    = s1_ff.px_lo;
      s2_in.colour   = s1_ff.colour;
   end

   // merge the pixel into the old byte
   always_comb begin
      byte_sel = s2_ff.addr[0];
      s2_idx   = s2_ff.addr[IDX_W:1];
      old_even = (lw_even_valid_ff && lw_even_idx_ff == s2_idx) ? lw_even_data_ff : rd_even_ff;
      old_odd  = (lw_odd_valid_ff && lw_odd_idx_ff == s2_idx) ? lw_odd_data_ff : rd_odd_ff;
      old_byte = byte_sel ? old_odd : old_even;
      bit_mask = PIX1_MASK >> s2_ff.px_lo;
      sh2      = {s2_ff.px_lo[1:0], 1'b0};
      sh4      = {s2_ff.px_lo[0], 2'b00};
      case (cfg.pixel_format)
         FMT_1BPP: begin
            new_byte = (s2_ff.colour == '0) ? (old_byte & ~bit_mask) : (old_byte | bit_mask);
         end
         FMT_2BPP: begin
            new_byte = (old_byte & ~(PIX2_MASK >> sh2)) | ({s2_ff.colour[1:0], 6'b0} >> sh2);
         end
         FMT_4BPP: begin
            new_byte = (old_byte & ~(PIX4_MASK >> sh4)) | ({s2_ff.colour[3:0], 4'b0} >> sh4);
         end
         default: begin
            new_byte = s2_ff.colour[7:0] & BYTE_MASK;
         end
      endcase
   end

   always_comb begin
      if (s2_ff.out_of_range) begin
         rsp_in.status       = STATUS_RANGE;
         rsp_in.byte_address = '0;
         rsp_in.written_data = '0;
         rsp_in.byte_count   = COUNT_NONE;
      end else if (cfg.pixel_format == FMT_16BPP) begin
         rsp_in.status       = STATUS_OK;
         rsp_in.byte_address = s2_ff.addr[ADDR_OUT_W-1:0];
         rsp_in.written_data = s2_ff.colour;
         rsp_in.byte_count   = COUNT_TWO;
      end else begin
         rsp_in.status       = STATUS_OK;
         rsp_in.byte_address = s2_ff.addr[ADDR_OUT_W-1:0];
         rsp_in.written_data = {8'h00, new_byte};
         rsp_in.byte_count   = COUNT_ONE;
      end
   end

   always_comb begin
      we_even     = 1'b0;
      we_odd      = 1'b0;
      w_idx_even  = s2_idx;
      w_idx_odd   = s2_idx;
      w_data_even = new_byte;
      w_data_odd  = new_byte;
      if (clearing_ff) begin
         we_even     = 1'b1;
         we_odd      = 1'b1;
         w_idx_even  = clear_idx_ff;
         w_idx_odd   = clear_idx_ff;
         w_data_even = '0;
         w_data_odd  = '0;
      end else if (s2_go && !s2_ff.out_of_range) begin
         if (cfg.pixel_format == FMT_16BPP) begin
            we_even = 1'b1;
            we_odd  = 1'b1;
            if (!byte_sel) begin
               w_data_even = s2_ff.colour[15:8];
               w_data_odd  = s2_ff.colour[7:0];
            end else begin
               // odd start: low byte goes to the next even entry
               w_data_odd  = s2_ff.colour[15:8];
               w_idx_even  = s2_ff.idx_next;
               w_data_even = s2_ff.colour[7:0];
            end
         end else if (byte_sel) begin
            we_odd = 1'b1;
         end else begin
            we_even = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (we_even) begin
         bank_even_ff[w_idx_even] <= w_data_even;
      end
      if (we_odd) begin
         bank_odd_ff[w_idx_odd] <= w_data_odd;
      end
      if (s1_go) begin
         rd_even_ff <= bank_even_ff[rd_idx];
         rd_odd_ff  <= bank_odd_ff[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_ff <= s1_in;
      end
      if (s1_go) begin
         s2_ff <= s2_in;
      end
      if (s2_go) begin
         out_ff <= rsp_in;
      end
      if (we_even) begin
         lw_even_idx_ff  <= w_idx_even;
         lw_even_data_ff <= w_data_even;
      end
      if (we_odd) begin
         lw_odd_idx_ff  <= w_idx_odd;
         lw_odd_data_ff <= w_data_odd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         s2_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         clearing_ff      <= 1'b1;
         clear_idx_ff     <= '0;
         lw_even_valid_ff <= 1'b0;
         lw_odd_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff      <= s1_valid_in;
         s2_valid_ff      <= s2_valid_in;
         out_valid_ff     <= out_valid_in;
         clearing_ff      <= clearing_in;
         clear_idx_ff     <= clear_idx_in;
         lw_even_valid_ff <= lw_even_valid_ff | we_even;
         lw_odd_valid_ff  <= lw_odd_valid_ff | we_odd;
      end
   end

endmodule

// ----- design/framebuffer_pixel_writer.sv -----
// Pixel writer into an internal packed byte framebuffer of FRAME_BYTES bytes. Each pixel write
// (x_pos, y_pos, colour) pushed in is bounds checked, mapped through the rotation and mirror
// registers onto panel coordinates, and merged by read-modify-write into the framebuffer in the
// configured pixel format; one result per write comes out, in order, with status, first byte
// address, written data and byte count. After reset the framebuffer is cleared one even/odd byte
// pair per cycle, and full stays high until the clear ends; the registers can be written
// meanwhile. Sustained rate is one pixel per cycle while results are popped: the framebuffer
// is two byte banks, each with one registered read and one write per cycle, and a write is
// forwarded to a read of the same entry issued in the same cycle. A pixel's result passes from
// its push transfer through a 4-entry queue, the row multiplier stage, the address and bank
// read stage, and the merge and write stage into the output register.
module framebuffer_pixel_writer import fbpw_pkg::*; #(
   parameter int FRAME_BYTES = 8192,
   parameter int MAX_DIM     = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  req_type               req_item,
   output logic                  empty,
   input  logic                  pop,
   output rsp_type               rsp_item,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type   cfg;
   point_type point;
   point_type q_head;
   logic      q_push;
   logic      q_pop;
   logic      q_full;
   logic      q_empty;
   logic      clearing;

   fbpw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   fbpw_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .cfg      (cfg),
      .push     (push),
      .req_item (req_item),
      .q_full   (q_full),
      .clearing (clearing),
      .full     (full),
      .q_push   (q_push),
      .point    (point)
   );

   fbpw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (point),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   fbpw_back #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .q_empty  (q_empty),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .clearing (clearing),
      .pop      (pop),
      .empty    (empty),
      .rsp_item (rsp_item)
   );

endmodule

// ----- design/fbpw_checker.sv -----
`include "framebuffer_pixel_writer_assert.svh"

module fbpw_checker import fbpw_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    full,
   input logic    empty,
   input logic    pop,
   input rsp_type rsp_item
);

   // a rejected pixel reports nothing written
   `FBPW_ASSERT_NOW(a_range_result_zero, clock, reset, !empty && rsp_item.status == STATUS_RANGE, rsp_item.byte_count == COUNT_NONE && rsp_item.byte_address == '0 && rsp_item.written_data == '0)

   `FBPW_ASSERT_NOW(a_written_has_bytes, clock, reset, !empty && rsp_item.status == STATUS_OK, rsp_item.byte_count == COUNT_ONE || rsp_item.byte_count == COUNT_TWO)

   // after reset the framebuffer clear holds off input and the output is empty
   `FBPW_ASSERT_NEXT(a_clear_after_reset, clock, reset, full && empty)

   `FBPW_ASSERT_NEXT(a_result_holds, clock, !reset && !empty && !pop, !empty && $stable(rsp_item))

endmodule

bind framebuffer_pixel_writer fbpw_checker u_fbpw_checker (
   .clock    (clock),
   .reset    (reset),
   .full     (full),
   .empty    (empty),
   .pop      (pop),
   .rsp_item (rsp_item)
);
